// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by rdr_queue
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// clocked property on aclk and aresetn
`define ASSERT_DEF(label, prop) \
    `ASSERT_CLK(label, aclk, aresetn, prop)

`endif

// ===== hw/rtl/rdr_pkg.sv =====
// types and constants shared by the raw depth to rgba8 export block
// no dependencies
`default_nettype none

package rdr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 18;
    localparam int BYTE_W   = 8;
    localparam int QDEPTH   = 2;

    localparam logic [BYTE_W-1:0] ALPHA_BYTE = 8'hFF;

    localparam logic [1:0] MODE_GRAY  = 2'd0;
    localparam logic [1:0] MODE_COPY  = 2'd1;
    localparam logic [1:0] MODE_BAYER = 2'd2;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_BRIGHT = 3'd1;
    localparam logic [2:0] REG_DEPTH  = 3'd2;
    localparam logic [2:0] REG_MAP    = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;

    localparam logic [1:0]  MODE_RST   = MODE_GRAY;
    localparam logic [3:0]  BRIGHT_RST = 4'd0;
    localparam logic [3:0]  DEPTH_RST  = 4'd4;
    localparam logic [7:0]  MAP_RST    = 8'd97;
    localparam logic [12:0] WIDTH_RST  = 13'd4096;

    typedef enum logic [1:0] {
        OP_GRAY,
        OP_COPY,
        OP_BAYER,
        OP_NONE
    } op_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  bright;
        logic [3:0]  depth;
        logic [7:0]  map;
        logic [12:0] row_width;
    } cfg_t;

    typedef struct packed {
        op_t                   op;
        logic [2:0][SUM_W-1:0] ch;
    } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rdr_front.sv =====
// front end: accepts samples, tracks row and column, keeps the line store
// and bins bayer quads into channel sums; uses rdr_pkg
`default_nettype none

module rdr_front import rdr_pkg::*; #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cfg_t                cfg_i,
    input  wire logic                s_valid_i,
    output logic                     s_ready_o,
    input  wire logic [SAMPLE_W-1:0] sample_i,
    input  wire logic                frame_start_i,
    output logic                     push_o,
    output entry_t                   entry_o,
    input  wire logic                q_ready_i
);

    localparam int CW = $clog2(MAX_ROW_WIDTH);
    localparam int WW = $clog2(MAX_ROW_WIDTH + 1);
    localparam int AW = (CW > 1) ? CW - 1 : 1;
    localparam int BD = (MAX_ROW_WIDTH + 1) / 2;

    logic [SAMPLE_W-1:0] even_mem [BD];
    logic [SAMPLE_W-1:0] odd_mem  [BD];

    logic [CW-1:0]       col_reg, col_next;
    logic                odd_reg, odd_next;
    logic [SAMPLE_W-1:0] held_reg;

    logic                a_valid_reg, a_valid_next;
    op_t                 a_op_reg;
    logic [SAMPLE_W-1:0] a_sample_reg;
    logic [SAMPLE_W-1:0] a_held_reg;
    logic [SAMPLE_W-1:0] rd_even_reg;
    logic [SAMPLE_W-1:0] rd_odd_reg;

    logic [WW-1:0]       width_eff;
    logic [CW-1:0]       col_eff;
    logic                odd_eff;
    logic [WW-1:0]       col_inc;
    logic                wrap;
    logic [AW-1:0]       mem_addr;
    op_t                 op_sel;
    logic                s_accept;
    logic                a_done;

    logic [3:0][SAMPLE_W-1:0] quad;
    logic [2:0][SUM_W-1:0]    sums;

    assign s_accept = s_valid_i && s_ready_o;
    assign push_o   = a_valid_reg && (a_op_reg != OP_NONE) && q_ready_i;
    assign a_done   = a_valid_reg && ((a_op_reg == OP_NONE) || q_ready_i);
    assign s_ready_o = !a_valid_reg || a_done;

    // effective row width, zero acts as one and large values clamp
    always_comb begin
        if (cfg_i.row_width == '0) begin
            width_eff = WW'(1);
        end else if (32'(cfg_i.row_width) > MAX_ROW_WIDTH) begin
            width_eff = WW'(MAX_ROW_WIDTH);
        end else begin
            width_eff = WW'(cfg_i.row_width);
        end
    end

    always_comb begin
        if (frame_start_i || (WW'(col_reg) >= width_eff)) begin
            col_eff = '0;
        end else begin
            col_eff = col_reg;
        end
        odd_eff  = frame_start_i ? 1'b0 : odd_reg;
        col_inc  = WW'(col_eff) + WW'(1);
        wrap     = (col_inc >= width_eff);
        col_next = wrap ? '0 : CW'(col_inc);
        odd_next = odd_eff ^ wrap;
        mem_addr = AW'(col_eff >> 1);
    end

    always_comb begin
        case (cfg_i.mode)
            MODE_GRAY: begin
                op_sel = OP_GRAY;
            end
            MODE_COPY: begin
                op_sel = OP_COPY;
            end
            MODE_BAYER: begin
                op_sel = (odd_eff && col_eff[0]) ? OP_BAYER : OP_NONE;
            end
            default: begin
                op_sel = OP_NONE;
            end
        endcase
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_accept) begin
            a_valid_next = 1'b1;
        end else if (a_done) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            odd_reg     <= 1'b0;
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            if (s_accept) begin
                col_reg <= col_next;
                odd_reg <= odd_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_op_reg     <= op_sel;
            a_sample_reg <= sample_i;
            a_held_reg   <= held_reg;
            if (odd_eff && !col_eff[0]) begin
                held_reg <= sample_i;
            end
        end
    end

    // line store split into even and odd column banks, one address per quad
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (!odd_eff && !col_eff[0]) begin
                even_mem[mem_addr] <= sample_i;
            end
            rd_even_reg <= even_mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (!odd_eff && col_eff[0]) begin
                odd_mem[mem_addr] <= sample_i;
            end
            rd_odd_reg <= odd_mem[mem_addr];
        end
    end

    assign quad[0] = rd_even_reg;
    assign quad[1] = rd_odd_reg;
    assign quad[2] = a_held_reg;
    assign quad[3] = a_sample_reg;

    always_comb begin
        sums = '0;
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 3; k++) begin
                if (cfg_i.map[2*i +: 2] == 2'(k)) begin
                    sums[k] = sums[k] + SUM_W'(quad[i]);
                end
            end
        end
    end

    always_comb begin
        entry_o.op = a_op_reg;
        if (a_op_reg == OP_BAYER) begin
            entry_o.ch = sums;
        end else begin
            for (int k = 0; k < 3; k++) begin
                entry_o.ch[k] = SUM_W'(a_sample_reg);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rdr_queue.sv =====
// two-entry queue between the front end and the byte emitter
// uses rdr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rdr_queue import rdr_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push_i,
    input  wire entry_t entry_i,
    output logic        ready_o,
    input  wire logic   pop_i,
    output logic        valid_o,
    output entry_t      entry_o
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int NW = $clog2(QDEPTH + 1);

    entry_t          mem_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg, count_next;

    assign ready_o = (count_reg != NW'(QDEPTH));
    assign valid_o = (count_reg != '0);
    assign entry_o = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_i) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop_i) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push_i && !pop_i) begin
            count_next = count_reg + NW'(1);
        end else if (!push_i && pop_i) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            mem_reg[wr_ptr_reg] <= entry_i;
        end
    end

    `ASSERT_DEF(a_count_bound, count_reg <= NW'(QDEPTH))
    `ASSERT_DEF(a_no_push_full, push_i |-> ready_o)
    `ASSERT_DEF(a_no_pop_empty, pop_i |-> valid_o)
    `ASSERT_DEF(a_count_up, (push_i && !pop_i) |=> (count_reg == $past(count_reg) + NW'(1)))
    `ASSERT_DEF(a_count_down, (!push_i && pop_i) |=> (count_reg == $past(count_reg) - NW'(1)))

endmodule

`default_nettype wire

// ===== hw/rtl/rdr_back.sv =====
// back end: scales and saturates one byte per cycle into the output register
// while the output is ready; uses rdr_pkg
`default_nettype none

module rdr_back import rdr_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire cfg_t   cfg_i,
    input  wire logic   q_valid_i,
    input  wire entry_t q_entry_i,
    output logic        q_pop_o,
    output logic        m_valid_o,
    input  wire logic   m_ready_i,
    output logic [BYTE_W-1:0] m_byte_o,
    output logic        m_last_o
);

    localparam logic [1:0] IDX_GREEN = 2'd1;
    localparam logic [1:0] IDX_ALPHA = 2'd3;
    localparam int SW = SUM_W + 16;

    logic [1:0]        idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    logic              load;
    logic              is_last;
    logic [3:0]        eff_bright;
    logic [4:0]        rshift;
    logic [SUM_W-1:0]  chan;
    logic [SW-1:0]     shifted;
    logic [BYTE_W-1:0] byte_val;

    assign load    = !valid_reg || m_ready_i;
    assign is_last = (q_entry_i.op == OP_COPY) || (idx_reg == IDX_ALPHA);
    assign q_pop_o = load && q_valid_i && is_last;

    always_comb begin
        eff_bright = (cfg_i.bright < cfg_i.depth) ? cfg_i.bright : cfg_i.depth;
        rshift     = {1'b0, cfg_i.depth};
        if ((q_entry_i.op == OP_BAYER) && (idx_reg == IDX_GREEN)) begin
            rshift = {1'b0, cfg_i.depth} + 5'd1;
        end
        chan     = (idx_reg == IDX_ALPHA) ? '0 : q_entry_i.ch[idx_reg];
        shifted  = (SW'(chan) << eff_bright) >> rshift;
        if (idx_reg == IDX_ALPHA) begin
            byte_val = ALPHA_BYTE;
        end else if (|shifted[SW-1:BYTE_W]) begin
            byte_val = ALPHA_BYTE;
        end else begin
            byte_val = shifted[BYTE_W-1:0];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = q_valid_i;
            if (q_valid_i) begin
                idx_next = is_last ? '0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && q_valid_i) begin
            byte_reg <= byte_val;
            last_reg <= is_last;
        end
    end

    assign m_valid_o = valid_reg;
    assign m_byte_o  = byte_reg;
    assign m_last_o  = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/raw_depth_to_rgba8_export.sv =====
// top level of the raw depth to rgba8 export block with its register port
// uses rdr_pkg, rdr_front, rdr_queue and rdr_back
//
//   channel   direction   payload
//   s_        in          tdata: sample[15:0]; tuser: frame_start
//   m_        out         tdata: pixel_byte[7:0]; tlast: last
//   apb       in/out      mode, brightness_shift, depth_shift, channel_map, row_width
//
// one sample enters per cycle while the queue has room; the back end sends one byte
// per cycle while the output is ready, so a grayscale or bayer quad item gives four
// bytes, a copy item one; input to first byte: line store read, queue, output register
// a two-entry queue lets the front keep taking samples while bytes stall
// reset is synchronous and clears counters, queue and valid flags, not the line store
`default_nettype none

module raw_depth_to_rgba8_export import rdr_pkg::*; #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // sample[15:0]
    input  wire logic        s_tuser,   // frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // pixel_byte[7:0]
    output logic             m_tlast
);

    cfg_t        cfg_reg;
    logic        cfg_wr;
    logic [2:0]  reg_idx;

    logic        push;
    logic        q_ready;
    entry_t      push_entry;
    logic        q_valid;
    logic        q_pop;
    entry_t      head_entry;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode      <= MODE_RST;
            cfg_reg.bright    <= BRIGHT_RST;
            cfg_reg.depth     <= DEPTH_RST;
            cfg_reg.map       <= MAP_RST;
            cfg_reg.row_width <= WIDTH_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MODE: begin
                    cfg_reg.mode <= pwdata[1:0];
                end
                REG_BRIGHT: begin
                    cfg_reg.bright <= pwdata[3:0];
                end
                REG_DEPTH: begin
                    cfg_reg.depth <= pwdata[3:0];
                end
                REG_MAP: begin
                    cfg_reg.map <= pwdata[7:0];
                end
                REG_WIDTH: begin
                    cfg_reg.row_width <= pwdata[12:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE: begin
                prdata = 32'(cfg_reg.mode);
            end
            REG_BRIGHT: begin
                prdata = 32'(cfg_reg.bright);
            end
            REG_DEPTH: begin
                prdata = 32'(cfg_reg.depth);
            end
            REG_MAP: begin
                prdata = 32'(cfg_reg.map);
            end
            REG_WIDTH: begin
                prdata = 32'(cfg_reg.row_width);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    rdr_front #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_i         (cfg_reg),
        .s_valid_i     (s_tvalid),
        .s_ready_o     (s_tready),
        .sample_i      (s_tdata),
        .frame_start_i (s_tuser),
        .push_o        (push),
        .entry_o       (push_entry),
        .q_ready_i     (q_ready)
    );

    rdr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .entry_i (push_entry),
        .ready_o (q_ready),
        .pop_i   (q_pop),
        .valid_o (q_valid),
        .entry_o (head_entry)
    );

    rdr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_i     (cfg_reg),
        .q_valid_i (q_valid),
        .q_entry_i (head_entry),
        .q_pop_o   (q_pop),
        .m_valid_o (m_tvalid),
        .m_ready_i (m_tready),
        .m_byte_o  (m_tdata),
        .m_last_o  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== verif/tb_raw_depth_to_rgba8_export.sv =====
`timescale 1ns / 1ps
// self-checking testbench for raw_depth_to_rgba8_export: apb register setup, sample stream in,
// byte stream out, every byte compared against an in-bench conversion of the accepted samples
// depends on rdr_pkg and raw_depth_to_rgba8_export

module tb_raw_depth_to_rgba8_export;
    import rdr_pkg::*;

    localparam int LINE_MAX = 4096;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RX_HOLD_CYCLES = 80;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic        frame_start;
        logic [15:0] sample;
    } raw_item_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } px_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // sample[15:0]
    logic        s_tuser = 1'b0; // frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // pixel_byte[7:0]
    logic        m_tlast;

    raw_item_t pending_samples[$];
    px_byte_t  expected_bytes[$];

    // shadow registers
    logic [1:0]  cfg_mode = MODE_RST;
    logic [3:0]  cfg_bright = BRIGHT_RST;
    logic [3:0]  cfg_depth = DEPTH_RST;
    logic [7:0]  cfg_map = MAP_RST;
    logic [12:0] cfg_width = WIDTH_RST;

    // conversion state
    logic [15:0] row_buf [LINE_MAX];
    logic [15:0] held_px = '0;
    int unsigned col_pos = 0;
    bit          odd_line = 1'b0;

    int err_count = 0;
    int cycle_count = 0;
    int send_gap_pct = 11;
    int recv_gap_pct = 50;
    int rx_hold_req = 0;
    int rx_hold_seen = 0;
    int rx_hold_cnt = 0;

    raw_depth_to_rgba8_export i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    function automatic logic [7:0] scale_byte(logic [63:0] v, int unsigned rsh);
        logic [63:0] r;
        int unsigned eff;
        eff = (cfg_bright < cfg_depth) ? cfg_bright : cfg_depth;
        r = (v << eff) >> rsh;
        return (r > 255) ? 8'hFF : r[7:0];
    endfunction

    function automatic void push_byte(logic [7:0] pixel, logic last);
        px_byte_t b;
        b.pixel = pixel;
        b.last = last;
        expected_bytes.push_back(b);
    endfunction

    function automatic void convert_sample(logic [15:0] smp, logic fs);
        int unsigned w;
        int unsigned c;
        logic [63:0] sums [4];
        logic [15:0] quad [4];
        logic [7:0]  v;
        w = cfg_width;
        if (w == 0) w = 1;
        if (w > LINE_MAX) w = LINE_MAX;
        if (fs) begin
            col_pos = 0;
            odd_line = 1'b0;
        end
        if (col_pos >= w) col_pos = 0;
        c = col_pos;
        case (cfg_mode)
            MODE_GRAY: begin
                v = scale_byte(64'(smp), cfg_depth);
                push_byte(v, 1'b0);
                push_byte(v, 1'b0);
                push_byte(v, 1'b0);
                push_byte(ALPHA_BYTE, 1'b1);
            end
            MODE_COPY: begin
                push_byte(scale_byte(64'(smp), cfg_depth), 1'b1);
            end
            MODE_BAYER: begin
                if (odd_line && c[0]) begin
                    quad[0] = row_buf[(c - 1) % LINE_MAX];
                    quad[1] = row_buf[c % LINE_MAX];
                    quad[2] = held_px;
                    quad[3] = smp;
                    for (int i = 0; i < 4; i++) sums[i] = '0;
                    for (int i = 0; i < 4; i++) sums[cfg_map[2*i +: 2]] += 64'(quad[i]);
                    push_byte(scale_byte(sums[0], cfg_depth), 1'b0);
                    push_byte(scale_byte(sums[1], cfg_depth + 1), 1'b0);
                    push_byte(scale_byte(sums[2], cfg_depth), 1'b0);
                    push_byte(ALPHA_BYTE, 1'b1);
                end
            end
            default: ;
        endcase
        if (!odd_line) row_buf[c % LINE_MAX] = smp;
        else if (!c[0]) held_px = smp;
        c++;
        if (c >= w) begin
            c = 0;
            odd_line = !odd_line;
        end
        col_pos = c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        $display("mismatch on %0s: got %0h, expected %0h", what, got, want);
    endtask

    // sender
    always @(posedge aclk) begin : sample_driver
        raw_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) convert_sample(s_tdata, s_tuser);
            if (!s_tvalid || s_tready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    nxt = pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.sample;
                    s_tuser <= nxt.frame_start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (rx_hold_cnt != 0) begin
            rx_hold_cnt <= rx_hold_cnt - 1;
        end else if (rx_hold_req != rx_hold_seen) begin
            rx_hold_cnt <= RX_HOLD_CYCLES;
            rx_hold_seen <= rx_hold_req;
        end
    end

    // receiver and checker
    always @(posedge aclk) begin : byte_monitor
        px_byte_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("item with nothing expected", m_tdata, 0);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.pixel) report_mismatch("pixel_byte", m_tdata, want.pixel);
                    if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
                end
            end
            m_tready <= (rx_hold_cnt == 0) && ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODE:   cfg_mode = val[1:0];
            REG_BRIGHT: cfg_bright = val[3:0];
            REG_DEPTH:  cfg_depth = val[3:0];
            REG_MAP:    cfg_map = val[7:0];
            REG_WIDTH:  cfg_width = val[12:0];
            default: ;
        endcase
    endtask

    // every item accepted and every byte back, then let the pipeline empty
    task automatic drain_all();
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_bytes.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_regs(logic [1:0] md, logic [3:0] br, logic [3:0] dp, logic [7:0] mp,
                            logic [12:0] wd);
        drain_all();
        apb_write(REG_MODE, 32'(md));
        apb_write(REG_BRIGHT, 32'(br));
        apb_write(REG_DEPTH, 32'(dp));
        apb_write(REG_MAP, 32'(mp));
        apb_write(REG_WIDTH, 32'(wd));
        @(negedge aclk);
    endtask

    task automatic push_sample(logic [15:0] smp, logic fs);
        raw_item_t it;
        it.sample = smp;
        it.frame_start = fs;
        pending_samples.push_back(it);
    endtask

    task automatic random_config(bit force_gray);
        logic [1:0]  md;
        logic [3:0]  br;
        logic [3:0]  dp;
        logic [7:0]  mp;
        logic [12:0] wd;
        int r;
        r = $urandom_range(9);
        md = (r < 3) ? MODE_GRAY : (r < 5) ? MODE_COPY : (r < 9) ? MODE_BAYER : MODE_UNUSED;
        if (force_gray) md = MODE_GRAY;
        dp = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        br = 4'($urandom_range(15));
        if ($urandom_range(4) == 0) mp = $urandom_range(1) ? 8'hFF : 8'h00;
        else mp = 8'($urandom_range(255));
        if (md == MODE_BAYER) begin
            if ($urandom_range(5) == 0) wd = 13'($urandom_range(9));
            else wd = 13'(2 * $urandom_range(6, 1));
        end else if ($urandom_range(3) == 0) begin
            wd = 13'($urandom_range(8191, 4097));
        end else begin
            wd = 13'($urandom_range(4096, 1));
        end
        set_regs(md, br, dp, mp, wd);
    endtask

    task automatic push_random(int n, bit open_frame);
        logic [15:0] smp;
        int i;
        for (i = 0; i < n; i++) begin
            case ($urandom_range(7))
                0: smp = 16'h0000;
                1: smp = 16'hFFFF;
                default: smp = 16'($urandom);
            endcase
            push_sample(smp, (open_frame && i == 0) || $urandom_range(39) == 0);
        end
    endtask

    initial begin
        for (int i = 0; i < LINE_MAX; i++) row_buf[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // grayscale at reset values, exact and just-saturating values
        push_sample(16'h0000, 1'b1);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0FF0, 1'b0);
        push_sample(16'h1000, 1'b0);

        // brightness clamped to zero depth
        set_regs(MODE_COPY, 4'd15, 4'd0, MAP_RST, 13'd16);
        push_sample(16'h0001, 1'b1);
        push_sample(16'h00FF, 1'b0);
        push_sample(16'h0100, 1'b0);

        set_regs(MODE_COPY, 4'd8, 4'd8, MAP_RST, 13'd16);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'h00FF, 1'b0);
        push_sample(16'h0080, 1'b0);

        // unused mode gives nothing
        set_regs(MODE_UNUSED, 4'd0, 4'd4, MAP_RST, 13'd16);
        push_sample(16'h1234, 1'b1);
        push_sample(16'hABCD, 1'b0);

        // one quad, full-scale
        set_regs(MODE_BAYER, 4'd0, 4'd8, 8'hE4, 13'd2);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'hFFFF, 1'b0);

        // odd width leaves an unpaired sample, channels summed
        set_regs(MODE_BAYER, 4'd2, 4'd2, 8'h00, 13'd3);
        push_sample(16'd10, 1'b1);
        push_sample(16'd20, 1'b0);
        push_sample(16'd30, 1'b0);
        push_sample(16'd40, 1'b0);
        push_sample(16'd50, 1'b0);
        push_sample(16'd60, 1'b0);

        // zero width acts as one
        set_regs(MODE_BAYER, 4'd0, 4'd4, 8'h55, 13'd0);
        push_sample(16'h4321, 1'b1);
        push_sample(16'h8765, 1'b0);

        // width above the line store, deepest shifts
        set_regs(MODE_GRAY, 4'd15, 4'd15, 8'hFF, 13'd8191);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'h8000, 1'b0);

        for (int p = 0; p < 12; p++) begin
            random_config(p == 8);
            if (p == 4) begin
                send_gap_pct = 50;
                recv_gap_pct = 11;
            end
            if (p == 8) begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            push_random(12, 1'b1);
            if (p == 8) rx_hold_req++;
            if (p == 9) drain_all();
            push_random(11, 1'b0);
        end

        drain_all();
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rdr_pkg.sv
hw/rtl/rdr_front.sv
hw/rtl/rdr_queue.sv
hw/rtl/rdr_back.sv
hw/rtl/raw_depth_to_rgba8_export.sv
verif/tb_raw_depth_to_rgba8_export.sv
